/* rtl/pcf_pkg.sv */
// shared types and constants of the packet capture filter
package pcf_pkg;

    // largest number of bytes one frame may pass on, whatever the snap length
    localparam int unsigned MAX_CAPTURE = 256;
    localparam logic [8:0]  SNAP_RESET  = 9'd256;

    // frame positions of the header fields we pick up
    localparam logic [15:0] POS_MAX    = 16'hFFFF;
    localparam logic [15:0] POS_ETH_HI = 16'd12;
    localparam logic [15:0] POS_ETH_LO = 16'd13;
    localparam logic [15:0] POS_IHL    = 16'd14;
    localparam logic [15:0] POS_LEN_HI = 16'd16;
    localparam logic [15:0] POS_LEN_LO = 16'd17;
    localparam logic [15:0] POS_PROTO  = 16'd23;

    // verdict limits
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] MIN_FRAME     = 16'd34;
    localparam logic [16:0] ETH_HDR_LEN   = 17'd14;
    localparam logic [15:0] IP_HDR_MIN    = 16'd20;
    localparam logic [15:0] IP_HDR_MAX    = 16'd60;

    // result kinds
    localparam logic ITEM_DATA = 1'b0;
    localparam logic ITEM_DESC = 1'b1;

    // timestamp split: q = ((t >> 9) * RECIP_1E9) >> 55, then one correction step
    localparam int unsigned STAMP_PRE_SHIFT = 9;
    localparam logic [34:0] RECIP_1E9       = 35'h4_4B82_FA09;
    localparam logic [29:0] NS_PER_SEC      = 30'd1000000000;
    localparam int unsigned DIV_LAT         = 4;

    // result queue depth, counted with beats still in the pipeline
    localparam int unsigned Q_DEPTH = 16;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        frame_end;
        logic [63:0] time_now_ns;
    } t_in_beat;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  out_byte;
        logic        capture_ok;
        logic [31:0] stamp_seconds;
        logic [29:0] stamp_nanos;
        logic [8:0]  captured_length;
        logic [16:0] original_length;
        logic        run_last;
    } t_out_beat;

    // what one input beat leaves for the output side, apart from the stamp
    typedef struct packed {
        logic        has_data;
        logic        has_desc;
        logic [7:0]  data_byte;
        logic        capture_ok;
        logic [8:0]  captured_length;
        logic [16:0] original_length;
    } t_frame_info;

    typedef struct packed {
        t_frame_info info;
        logic [31:0] stamp_seconds;
        logic [29:0] stamp_nanos;
    } t_queue_entry;

endpackage

/* rtl/pcf_parser.sv */
// frame tracker: byte position, header field capture and capture verdict
module pcf_parser #(
    parameter int unsigned MAX_CAPTURE = pcf_pkg::MAX_CAPTURE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  pcf_pkg::t_in_beat    i_beat,
    input  logic [8:0]           i_snap_length,
    output logic                 o_valid,
    output pcf_pkg::t_frame_info o_info,
    output logic [63:0]          o_time
);

    logic [15:0] r_pos;
    logic [15:0] r_ether_type;
    logic [3:0]  r_header_words;
    logic [15:0] r_ip_total_length;
    logic [7:0]  r_ip_protocol;
    logic        r_valid;
    pcf_pkg::t_frame_info r_info;
    logic [63:0] r_time;

    logic [15:0] n_pos;
    logic [15:0] n_ether_type;
    logic [3:0]  n_header_words;
    logic [15:0] n_ip_total_length;
    logic [7:0]  n_ip_protocol;
    pcf_pkg::t_frame_info n_info;

    logic [15:0] snap_ext;
    logic [15:0] snap_eff;
    logic [15:0] hdr_len;
    logic [15:0] cap_len;
    logic        verdict;

    // header field capture at fixed positions
    always_comb begin
        n_ether_type      = r_ether_type;
        n_header_words    = r_header_words;
        n_ip_total_length = r_ip_total_length;
        n_ip_protocol     = r_ip_protocol;
        unique case (r_pos)
            pcf_pkg::POS_ETH_HI: n_ether_type      = {i_beat.frame_byte, r_ether_type[7:0]};
            pcf_pkg::POS_ETH_LO: n_ether_type      = {r_ether_type[15:8], i_beat.frame_byte};
            pcf_pkg::POS_IHL:    n_header_words    = i_beat.frame_byte[3:0];
            pcf_pkg::POS_LEN_HI: n_ip_total_length = {i_beat.frame_byte,
                                                      r_ip_total_length[7:0]};
            pcf_pkg::POS_LEN_LO: n_ip_total_length = {r_ip_total_length[15:8],
                                                      i_beat.frame_byte};
            pcf_pkg::POS_PROTO:  n_ip_protocol     = i_beat.frame_byte;
            default: begin
            end
        endcase
    end

    // saturating position, which is the frame length after the final byte
    assign n_pos = (r_pos != pcf_pkg::POS_MAX) ? r_pos + 16'd1 : r_pos;

    // effective snap length
    assign snap_ext = {7'd0, i_snap_length};
    assign snap_eff = (snap_ext < 16'(MAX_CAPTURE)) ? snap_ext : 16'(MAX_CAPTURE);

    // verdict and lengths from the fields as they stand after this byte
    assign hdr_len = {10'd0, n_header_words, 2'b00};
    assign verdict = (n_pos >= pcf_pkg::MIN_FRAME) &&
                     (n_ether_type == pcf_pkg::ETH_TYPE_IPV4) &&
                     (hdr_len >= pcf_pkg::IP_HDR_MIN) &&
                     (hdr_len <= pcf_pkg::IP_HDR_MAX) &&
                     (pcf_pkg::ETH_HDR_LEN[15:0] + hdr_len <= n_pos) &&
                     ((n_ip_protocol == pcf_pkg::PROTO_TCP) ||
                      (n_ip_protocol == pcf_pkg::PROTO_UDP));
    assign cap_len = (n_pos < snap_eff) ? n_pos : snap_eff;

    always_comb begin
        n_info.has_data        = (r_pos < snap_eff);
        n_info.has_desc        = i_beat.frame_end;
        n_info.data_byte       = i_beat.frame_byte;
        n_info.capture_ok      = verdict;
        n_info.captured_length = cap_len[8:0];
        n_info.original_length = pcf_pkg::ETH_HDR_LEN + {1'b0, n_ip_total_length};
    end

    // frame state, cleared after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos             <= '0;
            r_ether_type      <= '0;
            r_header_words    <= '0;
            r_ip_total_length <= '0;
            r_ip_protocol     <= '0;
            r_valid           <= 1'b0;
        end else begin
            r_valid <= i_accept;
            if (i_accept) begin
                if (i_beat.frame_end) begin
                    r_pos             <= '0;
                    r_ether_type      <= '0;
                    r_header_words    <= '0;
                    r_ip_total_length <= '0;
                    r_ip_protocol     <= '0;
                end else begin
                    r_pos             <= n_pos;
                    r_ether_type      <= n_ether_type;
                    r_header_words    <= n_header_words;
                    r_ip_total_length <= n_ip_total_length;
                    r_ip_protocol     <= n_ip_protocol;
                end
            end
        end
    end

    // beat payload register
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_info <= n_info;
            r_time <= i_beat.time_now_ns;
        end
    end

    assign o_valid = r_valid;
    assign o_info  = r_info;
    assign o_time  = r_time;

endmodule

/* rtl/pcf_stamp_div.sv */
// timestamp split into seconds and nanoseconds, four register stages
module pcf_stamp_div (
    input  logic        i_clk,
    input  logic [63:0] i_time,
    output logic [31:0] o_seconds,
    output logic [29:0] o_nanos
);

    logic [54:0] x;
    logic [31:0] x_lo;
    logic [22:0] x_hi;
    logic [31:0] m_lo;
    logic [2:0]  m_hi;

    logic [63:0] p_ll;
    logic [34:0] p_lh;
    logic [54:0] p_hl;
    logic [25:0] p_hh;
    logic [89:0] p_sum;
    logic [60:0] q_prod;
    logic [30:0] rem;

    logic [63:0] r_p_ll;
    logic [34:0] r_p_lh;
    logic [54:0] r_p_hl;
    logic [25:0] r_p_hh;
    logic [30:0] r_t1;
    logic [31:0] r_q2;
    logic [30:0] r_t2;
    logic [30:0] r_prod3;
    logic [31:0] r_q3;
    logic [30:0] r_t3;
    logic [31:0] r_seconds;
    logic [29:0] r_nanos;

    // stage 1: partial products of (t >> 9) times the reciprocal
    assign x    = i_time[63:pcf_pkg::STAMP_PRE_SHIFT];
    assign x_lo = x[31:0];
    assign x_hi = x[54:32];
    assign m_lo = pcf_pkg::RECIP_1E9[31:0];
    assign m_hi = pcf_pkg::RECIP_1E9[34:32];
    assign p_ll = x_lo * m_lo;
    assign p_lh = x_lo * m_hi;
    assign p_hl = x_hi * m_lo;
    assign p_hh = x_hi * m_hi;

    // stage 2: sum of partials, estimate is the true quotient or one short
    assign p_sum = {26'd0, r_p_ll} +
                   ({55'd0, r_p_lh} << 32) +
                   ({35'd0, r_p_hl} << 32) +
                   ({64'd0, r_p_hh} << 64);

    // stage 3: low bits of estimate times one second, enough for the remainder
    assign q_prod = r_q2[30:0] * pcf_pkg::NS_PER_SEC;

    // stage 4: remainder below two seconds, one correction step
    assign rem = r_t3 - r_prod3;

    always_ff @(posedge i_clk) begin
        r_p_ll  <= p_ll;
        r_p_lh  <= p_lh;
        r_p_hl  <= p_hl;
        r_p_hh  <= p_hh;
        r_t1    <= i_time[30:0];
        r_q2    <= p_sum[86:55];
        r_t2    <= r_t1;
        r_prod3 <= q_prod[30:0];
        r_q3    <= r_q2;
        r_t3    <= r_t2;
        if (rem >= {1'b0, pcf_pkg::NS_PER_SEC}) begin
            r_seconds <= r_q3 + 32'd1;
            r_nanos   <= 30'(rem - {1'b0, pcf_pkg::NS_PER_SEC});
        end else begin
            r_seconds <= r_q3;
            r_nanos   <= rem[29:0];
        end
    end

    assign o_seconds = r_seconds;
    assign o_nanos   = r_nanos;

endmodule

/* rtl/pcf_out_queue.sv */
// result queue: an entry per beat with results, sent as a data and/or a descriptor beat
module pcf_out_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  pcf_pkg::t_queue_entry i_entry,
    output logic                  o_valid,
    input  logic                  i_stall,
    output pcf_pkg::t_out_beat    o_beat,
    output logic                  o_pop
);

    localparam int unsigned AW = $clog2(pcf_pkg::Q_DEPTH);

    pcf_pkg::t_queue_entry r_mem [pcf_pkg::Q_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;
    logic          r_second;

    pcf_pkg::t_queue_entry head;
    logic show_desc;
    logic take;
    logic pop;

    assign head      = r_mem[r_rd_ptr];
    assign show_desc = r_second || !head.info.has_data;
    assign take      = o_valid && !i_stall;
    assign pop       = take && (show_desc || !head.info.has_desc);

    // beat formatting, unused fields zero
    always_comb begin
        o_beat = '0;
        if (show_desc) begin
            o_beat.item_kind       = pcf_pkg::ITEM_DESC;
            o_beat.capture_ok      = head.info.capture_ok;
            o_beat.stamp_seconds   = head.stamp_seconds;
            o_beat.stamp_nanos     = head.stamp_nanos;
            o_beat.captured_length = head.info.captured_length;
            o_beat.original_length = head.info.original_length;
            o_beat.run_last        = 1'b1;
        end else begin
            o_beat.item_kind = pcf_pkg::ITEM_DATA;
            o_beat.out_byte  = head.info.data_byte;
            o_beat.run_last  = !head.info.has_desc;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers, fill count and descriptor phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_second <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
            if (pop) begin
                r_second <= 1'b0;
            end else if (take) begin
                r_second <= 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_pop   = pop;

endmodule

/* rtl/packet_capture_filter_core.sv */
// packet capture filter top level: config register, pipeline alignment, queue credit
// Takes one Ethernet frame byte per beat and can accept a beat every cycle while o_stall is
// low. Each byte at a position below the effective snap length (the snap length register,
// at most MAX_CAPTURE) comes out as a data beat; the final byte of a frame also gives a
// descriptor beat with the verdict, the timestamp split into seconds and nanoseconds, the
// captured and the original length. Results pass the parser register and the delay line
// into the result queue. The output sends one beat per cycle while i_stall is low, so a
// frame end with a data beat and a descriptor sends them as two beats, data first. Input
// stall is raised while the 16-entry result queue, counted with the beats in the five-stage
// pipeline, has no free entry. Write the snap length only while the block is idle.
module packet_capture_filter_core #(
    parameter int unsigned MAX_CAPTURE = pcf_pkg::MAX_CAPTURE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [8:0]         i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  pcf_pkg::t_in_beat  i_beat,
    output logic               o_valid,
    input  logic               i_stall,
    output pcf_pkg::t_out_beat o_beat
);

    localparam int unsigned UW = $clog2(pcf_pkg::Q_DEPTH + 1);

    logic [8:0]  r_snap_length;
    logic [UW-1:0] r_used;
    logic [UW-1:0] n_used;
    logic        r_dly_valid [pcf_pkg::DIV_LAT];
    pcf_pkg::t_frame_info r_dly_info [pcf_pkg::DIV_LAT];

    logic        accept;
    logic        prs_valid;
    pcf_pkg::t_frame_info prs_info;
    logic [63:0] prs_time;
    logic [31:0] stamp_seconds;
    logic [29:0] stamp_nanos;
    pcf_pkg::t_frame_info aligned;
    logic        aligned_valid;
    logic        push;
    logic        drop;
    logic        pop;
    pcf_pkg::t_queue_entry entry;

    // snap length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_length <= pcf_pkg::SNAP_RESET;
        end else if (i_cfg_we) begin
            r_snap_length <= i_cfg_wdata;
        end
    end

    assign o_stall = (r_used == UW'(pcf_pkg::Q_DEPTH));
    assign accept  = i_valid && !o_stall;

    pcf_parser #(
        .MAX_CAPTURE (MAX_CAPTURE)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_beat        (i_beat),
        .i_snap_length (r_snap_length),
        .o_valid       (prs_valid),
        .o_info        (prs_info),
        .o_time        (prs_time)
    );

    pcf_stamp_div u_stamp_div (
        .i_clk     (i_clk),
        .i_time    (prs_time),
        .o_seconds (stamp_seconds),
        .o_nanos   (stamp_nanos)
    );

    // frame info delayed to line up with the timestamp split
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pcf_pkg::DIV_LAT; i++) begin
                r_dly_valid[i] <= 1'b0;
            end
        end else begin
            r_dly_valid[0] <= prs_valid;
            for (int i = 1; i < pcf_pkg::DIV_LAT; i++) begin
                r_dly_valid[i] <= r_dly_valid[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dly_info[0] <= prs_info;
        for (int i = 1; i < pcf_pkg::DIV_LAT; i++) begin
            r_dly_info[i] <= r_dly_info[i-1];
        end
    end

    assign aligned       = r_dly_info[pcf_pkg::DIV_LAT-1];
    assign aligned_valid = r_dly_valid[pcf_pkg::DIV_LAT-1];
    assign push = aligned_valid && (aligned.has_data || aligned.has_desc);
    assign drop = aligned_valid && !(aligned.has_data || aligned.has_desc);

    always_comb begin
        entry.info          = aligned;
        entry.stamp_seconds = stamp_seconds;
        entry.stamp_nanos   = stamp_nanos;
    end

    pcf_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_beat  (o_beat),
        .o_pop   (pop)
    );

    // queue credit: reserved on accept, freed on pop or when a beat yields nothing
    always_comb begin
        n_used = r_used;
        if (accept) begin
            n_used = n_used + 1'b1;
        end
        if (pop) begin
            n_used = n_used - 1'b1;
        end
        if (drop) begin
            n_used = n_used - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

`ifndef SYNTHESIS
    // credit never runs past the queue depth
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(pcf_pkg::Q_DEPTH))
        else $error("queue credit above depth");

    // a descriptor always closes the results of its byte
    a_desc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_beat.item_kind == pcf_pkg::ITEM_DESC)) |-> o_beat.run_last)
        else $error("descriptor without run_last");

    // split timestamp keeps nanoseconds below one second
    a_nanos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_beat.item_kind == pcf_pkg::ITEM_DESC)) |->
        (o_beat.stamp_nanos < pcf_pkg::NS_PER_SEC))
        else $error("nanoseconds out of range");

    // no beat comes out without one having gone in
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_used != '0))
        else $error("output valid with no credit in use");
`endif

endmodule

/* bench/packet_capture_filter_core_test.sv */
// self-checking bench for the packet capture filter core: directed table, then random frames
module packet_capture_filter_core_test;

    localparam logic [63:0] NS_PER_S  = 64'd1000000000;
    // pipeline depth plus margin, waited out before config writes and at the end
    localparam int          PIPE_WAIT = 12;
    localparam int          PHASES    = 9;
    localparam int          PHASE_BEATS = 90;

    // one row of the directed table; typed rows carry their own two expected beats
    typedef struct packed {
        pcf_pkg::t_in_beat  beat;
        logic               typed;
        pcf_pkg::t_out_beat exp_data;
        pcf_pkg::t_out_beat exp_desc;
    } t_dir_row;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [8:0]         i_cfg_wdata = '0;
    logic               i_valid     = 1'b0;
    pcf_pkg::t_in_beat  i_beat      = '0;
    logic               i_stall     = 1'b0;
    logic               o_stall;
    logic               o_valid;
    pcf_pkg::t_out_beat o_beat;

    packet_capture_filter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_beat      (i_beat),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_beat      (o_beat)
    );

    // frame tracking state of the predictor
    logic [8:0]  snap_cfg     = pcf_pkg::SNAP_RESET;
    logic [15:0] frame_pos    = '0;
    logic [15:0] eth_type_acc = '0;
    logic [3:0]  ihl_nibble   = '0;
    logic [15:0] ip_len_acc   = '0;
    logic [7:0]  ip_proto_acc = '0;

    pcf_pkg::t_out_beat expected_beats[$];
    t_dir_row  dir_tab[$];
    int        mismatch_count = 0;
    int        beats_sent     = 0;
    int        send_idle_pct  = 0;
    int        recv_idle_pct  = 0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // timeout
    initial begin
        #6000000;
        $display("packet_capture_filter_core_test: errors");
        $finish;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // predict the beats one accepted input beat causes
    task automatic capture_predict(input pcf_pkg::t_in_beat b, input bit keep);
        int          pos;
        int          snap_eff;
        int          flen;
        int          hlen;
        logic        verdict;
        logic [63:0] secs;
        logic [63:0] nanos;
        pcf_pkg::t_out_beat r;
        pos      = frame_pos;
        snap_eff = (snap_cfg < pcf_pkg::MAX_CAPTURE) ? int'(snap_cfg)
                                                     : int'(pcf_pkg::MAX_CAPTURE);
        // header field pickup
        case (pos)
            12: eth_type_acc[15:8] = b.frame_byte;
            13: eth_type_acc[7:0]  = b.frame_byte;
            14: ihl_nibble         = b.frame_byte[3:0];
            16: ip_len_acc[15:8]   = b.frame_byte;
            17: ip_len_acc[7:0]    = b.frame_byte;
            23: ip_proto_acc       = b.frame_byte;
            default: ;
        endcase
        if (frame_pos != pcf_pkg::POS_MAX) frame_pos = frame_pos + 16'd1;
        // data beat while below the snap length
        if (pos < snap_eff && keep) begin
            r = {pcf_pkg::ITEM_DATA, b.frame_byte, 1'b0, 32'd0, 30'd0, 9'd0, 17'd0,
                 ~b.frame_end};
            expected_beats.push_back(r);
        end
        // descriptor on the final byte
        if (b.frame_end) begin
            flen    = frame_pos;
            hlen    = ihl_nibble * 4;
            verdict = (flen >= 34) && (eth_type_acc == pcf_pkg::ETH_TYPE_IPV4) &&
                      (hlen >= 20) && (hlen <= 60) && (14 + hlen <= flen) &&
                      (ip_proto_acc == pcf_pkg::PROTO_TCP ||
                       ip_proto_acc == pcf_pkg::PROTO_UDP);
            secs    = b.time_now_ns / NS_PER_S;
            nanos   = b.time_now_ns % NS_PER_S;
            r = {pcf_pkg::ITEM_DESC, 8'd0, verdict, secs[31:0], nanos[29:0],
                 9'((flen < snap_eff) ? flen : snap_eff),
                 pcf_pkg::ETH_HDR_LEN + {1'b0, ip_len_acc}, 1'b1};
            if (keep) expected_beats.push_back(r);
            frame_pos    = '0;
            eth_type_acc = '0;
            ihl_nibble   = '0;
            ip_len_acc   = '0;
            ip_proto_acc = '0;
        end
    endtask

    // drive one input beat, holding it until accepted
    task automatic send_beat(input pcf_pkg::t_in_beat b, input bit keep);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_beat  <= b;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        beats_sent++;
        capture_predict(b, keep);
    endtask

    // one frame, either shaped like ipv4 with mostly sane header fields or pure noise
    task automatic send_frame(input int len, input bit ipv4_like);
        logic [15:0] etype;
        logic [15:0] tot_len;
        logic [7:0]  vihl;
        logic [7:0]  proto;
        logic [7:0]  bv;
        pcf_pkg::t_in_beat b;
        int          r;
        etype   = ($urandom_range(9) == 0) ? 16'($urandom) : pcf_pkg::ETH_TYPE_IPV4;
        vihl    = {4'($urandom), ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5};
        tot_len = ($urandom_range(4) == 0) ? 16'($urandom) : 16'(len - 14);
        r       = $urandom_range(9);
        proto   = (r < 4) ? pcf_pkg::PROTO_TCP :
                  (r < 8) ? pcf_pkg::PROTO_UDP : 8'($urandom);
        for (int i = 0; i < len; i++) begin
            bv = 8'($urandom);
            if (ipv4_like) begin
                case (i)
                    12: bv = etype[15:8];
                    13: bv = etype[7:0];
                    14: bv = vihl;
                    16: bv = tot_len[15:8];
                    17: bv = tot_len[7:0];
                    23: bv = proto;
                    default: ;
                endcase
            end
            b.frame_byte  = bv;
            b.frame_end   = (i == len - 1);
            b.time_now_ns = {$urandom, $urandom};
            send_beat(b, 1'b1);
        end
    endtask

    // hold the sender until every expected beat has come and the pipeline is empty
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (PIPE_WAIT) @(posedge i_clk);
    endtask

    function automatic void dir_add(input pcf_pkg::t_in_beat b, input logic typed,
                                    input pcf_pkg::t_out_beat ed,
                                    input pcf_pkg::t_out_beat es);
        t_dir_row row;
        row.beat     = b;
        row.typed    = typed;
        row.exp_data = ed;
        row.exp_desc = es;
        dir_tab.push_back(row);
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    // output checker
    always @(posedge i_clk) begin
        pcf_pkg::t_out_beat e;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat expected none actual %h", $time, o_beat);
                mismatch_count++;
            end else begin
                e = expected_beats.pop_front();
                check_field("item_kind", e.item_kind, o_beat.item_kind);
                check_field("out_byte", e.out_byte, o_beat.out_byte);
                check_field("capture_ok", e.capture_ok, o_beat.capture_ok);
                check_field("stamp_seconds", e.stamp_seconds, o_beat.stamp_seconds);
                check_field("stamp_nanos", e.stamp_nanos, o_beat.stamp_nanos);
                check_field("captured_length", e.captured_length, o_beat.captured_length);
                check_field("original_length", e.original_length, o_beat.original_length);
                check_field("run_last", e.run_last, o_beat.run_last);
            end
        end
    end

    // stimulus
    initial begin
        logic [8:0] snap_plan [PHASES];
        logic [7:0] bv;
        int         start;
        int         len;
        int         r;
        bit         paused;
        t_dir_row   row;

        // one-byte frames right after reset: captured length one, header fields all zero
        dir_add({8'hFF, 1'b1, 64'd0}, 1'b1,
                {pcf_pkg::ITEM_DATA, 8'hFF, 1'b0, 32'd0, 30'd0, 9'd0, 17'd0, 1'b0},
                {pcf_pkg::ITEM_DESC, 8'h00, 1'b0, 32'd0, 30'd0, 9'd1, 17'd14, 1'b1});
        dir_add({8'h00, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
                {pcf_pkg::ITEM_DATA, 8'h00, 1'b0, 32'd0, 30'd0, 9'd0, 17'd0, 1'b0},
                {pcf_pkg::ITEM_DESC, 8'h00, 1'b0, 32'd1266874889, 30'd709551615, 9'd1,
                 17'd14, 1'b1});
        // short udp-looking frame with the largest total length: verdict fails on size
        for (int i = 0; i < 24; i++) begin
            case (i)
                12: bv = 8'h08;
                13: bv = 8'h00;
                14: bv = 8'h45;
                16, 17: bv = 8'hFF;
                23: bv = pcf_pkg::PROTO_UDP;
                default: bv = (i < 12 && i[0]) ? 8'hFF : 8'h00;
            endcase
            dir_add({bv, i == 23, 64'd999999999}, 1'b0, '0, '0);
        end

        snap_plan = '{9'd1, 9'd0, 9'd511, 9'd17, 9'($urandom_range(1, 256)), 9'd255,
                      9'd34, 9'd511, 9'd256};
        paused = 1'b0;

        // reset
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_tab[k]) begin
            row = dir_tab[k];
            send_beat(row.beat, !row.typed);
            if (row.typed) begin
                expected_beats.push_back(row.exp_data);
                expected_beats.push_back(row.exp_desc);
            end
        end

        // random phases, each with its own snap length and one of three idling patterns
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            send_idle_pct = (ph < 3) ? 21 : (ph < 6) ? 88 : 0;
            recv_idle_pct = (ph < 3) ? 88 : (ph < 6) ? 21 : 0;
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= snap_plan[ph];
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            snap_cfg = snap_plan[ph];
            start = beats_sent;
            while (beats_sent - start < PHASE_BEATS) begin
                r = $urandom_range(99);
                len = (r < 8) ? $urandom_range(1, 33) :
                      (r < 93) ? $urandom_range(34, 90) : $urandom_range(91, 300);
                send_frame(len, $urandom_range(4) != 0);
                // sender holds off mid-phase until the output side has caught up
                if (ph == 4 && !paused && beats_sent - start > 60) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        if (mismatch_count == 0 && expected_beats.size() == 0) begin
            $display("packet_capture_filter_core_test: clean");
        end else begin
            $display("packet_capture_filter_core_test: errors");
        end
        $finish;
    end

endmodule
